/* design/utf16_to_utf8_transcoder_unit_assert.svh */
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_unit assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_TRANSCODER_UNIT_ASSERT_SVH
`define UTF16_TO_UTF8_TRANSCODER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define U16U8_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be true outside reset
`define U16U8_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define U16U8_ASSERT(name, clk, rst_n, prop, msg)
`define U16U8_ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif

`endif

/* design/u16u8_pkg.sv */
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants of the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  // default depth of the run queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic REG_BYTE_ORDER = 1'b0;

  // byte order codes
  localparam logic ORDER_LITTLE = 1'b0;
  localparam logic ORDER_BIG    = 1'b1;

  // surrogate prefixes (top 6 bits of a code unit)
  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

  // offset of the supplementary planes, applied to code point bits 20:10
  localparam logic [10:0] SUPP_OFFSET_HI = 11'h040;

  // utf-8 lead and continuation prefixes
  localparam logic [1:0] CONT_TAG  = 2'b10;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  // one input beat
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } in_item_t;

  // one result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // all utf-8 bytes caused by one code unit
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } run_t;

endpackage

/* design/u16u8_front.sv */
// ----------------------------------------------------------------------------
// u16u8_front
// Pairs input bytes into code units, tracks surrogates and builds utf-8 runs.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_order_i,
  input  logic                accept_i,
  input  u16u8_pkg::in_item_t item_i,
  output logic                run_valid_o,
  output u16u8_pkg::run_t     run_o
);
  import u16u8_pkg::*;

  logic [7:0]  held_byte_q, held_byte_d;
  logic        have_half_q, have_half_d;
  logic [9:0]  hs_bits_q, hs_bits_d;
  logic        awaiting_q, awaiting_d;

  logic [15:0] unit;
  logic        is_low, is_high;
  logic [10:0] cp_hi;
  logic [20:0] cp;

  // assemble the code unit in the selected byte order
  always_comb begin
    if (byte_order_i == ORDER_BIG) begin
      unit = {held_byte_q, item_i.in_byte};
    end else begin
      unit = {item_i.in_byte, held_byte_q};
    end
  end

  assign is_low  = (unit[15:10] == LOW_SURR_TAG);
  assign is_high = (unit[15:10] == HIGH_SURR_TAG);
  assign cp_hi   = {1'b0, hs_bits_q} + SUPP_OFFSET_HI;
  assign cp      = {cp_hi[10:0], unit[9:0]};

  // classify the unit and build its run
  always_comb begin
    held_byte_d = held_byte_q;
    have_half_d = have_half_q;
    hs_bits_d   = hs_bits_q;
    awaiting_d  = awaiting_q;
    run_valid_o = 1'b0;
    run_o       = '0;
    if (accept_i) begin
      if (!have_half_q) begin
        if (item_i.end_of_buffer) begin
          awaiting_d = 1'b0;
        end else begin
          held_byte_d = item_i.in_byte;
          have_half_d = 1'b1;
        end
      end else begin
        have_half_d = 1'b0;
        if (awaiting_q) begin
          awaiting_d = 1'b0;
          if (is_low) begin
            run_valid_o    = 1'b1;
            run_o.bytes[0] = {LEAD4_TAG, cp[20:18]};
            run_o.bytes[1] = {CONT_TAG, cp[17:12]};
            run_o.bytes[2] = {CONT_TAG, cp[11:6]};
            run_o.bytes[3] = {CONT_TAG, cp[5:0]};
            run_o.last_idx = 2'd3;
          end
        end else if (is_high) begin
          awaiting_d = 1'b1;
          hs_bits_d  = unit[9:0];
        end else if (unit[15:7] == '0) begin
          run_valid_o    = 1'b1;
          run_o.bytes[0] = unit[7:0];
          run_o.last_idx = 2'd0;
        end else if (unit[15:11] == '0) begin
          run_valid_o    = 1'b1;
          run_o.bytes[0] = {LEAD2_TAG, unit[10:6]};
          run_o.bytes[1] = {CONT_TAG, unit[5:0]};
          run_o.last_idx = 2'd1;
        end else begin
          run_valid_o    = 1'b1;
          run_o.bytes[0] = {LEAD3_TAG, unit[15:12]};
          run_o.bytes[1] = {CONT_TAG, unit[11:6]};
          run_o.bytes[2] = {CONT_TAG, unit[5:0]};
          run_o.last_idx = 2'd2;
        end
      end
    end
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_byte_q <= '0;
      have_half_q <= 1'b0;
      hs_bits_q   <= '0;
      awaiting_q  <= 1'b0;
    end else begin
      held_byte_q <= held_byte_d;
      have_half_q <= have_half_d;
      hs_bits_q   <= hs_bits_d;
      awaiting_q  <= awaiting_d;
    end
  end

endmodule

/* design/u16u8_fifo.sv */
// ----------------------------------------------------------------------------
// u16u8_fifo
// Short queue of utf-8 runs between the front and the back.
// ----------------------------------------------------------------------------
module u16u8_fifo #(
  parameter int unsigned Depth = u16u8_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  u16u8_pkg::run_t wr_run_i,
  output logic            full_o,
  input  logic            rd_en_i,
  output logic            valid_o,
  output u16u8_pkg::run_t rd_run_o
);
  import u16u8_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  run_t            entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o   = (count_q == FullCnt);
  assign valid_o  = (count_q != '0);
  assign rd_run_o = entries_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entries_q[wr_ptr_q] <= wr_run_i;
    end
  end

endmodule

/* design/u16u8_back.sv */
// ----------------------------------------------------------------------------
// u16u8_back
// Serializes queued runs into single utf-8 beats behind an output register.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  u16u8_pkg::run_t      q_run_i,
  output logic                 q_pop_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output u16u8_pkg::out_item_t item_o
);
  import u16u8_pkg::*;

  run_t       run_q;
  logic [1:0] idx_q, idx_d;
  logic       busy_q, busy_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q;

  logic advance, finishing, take;

  // while a run is in progress, one byte moves to the output register whenever it is free or drained
  assign advance   = busy_q && (!out_valid_q || pop_i);
  assign finishing = advance && (idx_q == run_q.last_idx);
  assign take      = q_valid_i && (!busy_q || finishing);
  assign q_pop_o   = take;
  assign empty_o   = !out_valid_q;
  assign item_o    = out_q;

  // sequencing of the current run
  always_comb begin
    idx_d       = idx_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      idx_d       = idx_q + 1'b1;
      if (finishing) begin
        busy_d = 1'b0;
      end
    end
    if (take) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      run_q <= q_run_i;
    end
    if (advance) begin
      out_q.out_byte    <= run_q.bytes[idx_q];
      out_q.last_of_run <= (idx_q == run_q.last_idx);
    end
  end

endmodule

/* design/utf16_to_utf8_transcoder_unit.sv */
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_unit
// UTF-16 byte stream in, UTF-8 byte stream out, with selectable byte order.
// ----------------------------------------------------------------------------
// Input channel: push/full queue interface, one UTF-16 byte per beat plus an
// end-of-buffer flag. A beat is taken when push is high and full is low.
// Output channel: empty/pop queue interface, one UTF-8 byte per beat; the
// last beat of each UTF-8 sequence carries last_of_run.
// Configuration: APB-style port, register 0 (byte address 0) is byte_order,
// 0 little-endian, 1 big-endian. Write it only while the block is idle.
// Path: the second byte of a unit is written into the run queue, then loaded
// into the run register, then into the output register.
// Throughput: one input beat per cycle while the run queue has room; the
// back end sends one UTF-8 byte per cycle while the output is popped, so
// characters with longer UTF-8 sequences lower the sustained input rate.
// Reset: decoder state and byte order are cleared, queue and output register
// are emptied.
// Stall: when pop stays low the output register holds its beat, the back end
// stops, the run queue fills and full rises; no beat is lost.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_unit #(
  parameter int unsigned QueueDepth = u16u8_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input queue side
  input  logic                 push,
  output logic                 full,
  input  u16u8_pkg::in_item_t  in_item_i,
  // result queue side
  output logic                 empty,
  input  logic                 pop,
  output u16u8_pkg::out_item_t out_item_o,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import u16u8_pkg::*;

`include "utf16_to_utf8_transcoder_unit_assert.svh"

  logic byte_order_q;
  logic cfg_write;
  logic in_accept;
  logic run_valid;
  run_t run_push;
  logic q_full, q_valid, q_pop;
  run_t q_run;

  // configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_order_q <= ORDER_LITTLE;
    end else if (cfg_write && (paddr[2] == REG_BYTE_ORDER)) begin
      byte_order_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_BYTE_ORDER) ? {31'd0, byte_order_q} : 32'd0;

  // input handshake
  assign full      = q_full;
  assign in_accept = push && !q_full;

  u16u8_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_order_i (byte_order_q),
    .accept_i     (in_accept),
    .item_i       (in_item_i),
    .run_valid_o  (run_valid),
    .run_o        (run_push)
  );

  u16u8_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (run_valid),
    .wr_run_i (run_push),
    .full_o   (q_full),
    .rd_en_i  (q_pop),
    .valid_o  (q_valid),
    .rd_run_o (q_run)
  );

  u16u8_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_run_i   (q_run),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .item_o    (out_item_o)
  );

  // checks
  `U16U8_ASSERT_NEVER(a_no_push_when_full, clk_i, rst_ni, run_valid && q_full, "run written into a full queue")
  `U16U8_ASSERT_NEVER(a_no_pop_when_empty, clk_i, rst_ni, q_pop && !q_valid, "run taken from an empty queue")
  `U16U8_ASSERT(a_no_invented_beat, clk_i, rst_ni, (!q_valid && !u_back.busy_q && (empty || pop)) |=> empty, "result beat appeared with no run pending")
  `U16U8_ASSERT(a_cfg_write, clk_i, rst_ni, (cfg_write && (paddr[2] == REG_BYTE_ORDER)) |=> (byte_order_q == $past(pwdata[0])), "byte order register not written")

endmodule
